[design/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCLM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCLM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/tclm_pkg.sv]
`timescale 1ns / 1ps
package tclm_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_BUILD  = 2'd2,
    CMD_MAP    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BINIT,
    ST_CHK,
    ST_RD,
    ST_CAP,
    ST_AB,
    ST_P1,
    ST_P2,
    ST_DINIT,
    ST_DIV,
    ST_WR,
    ST_PRD,
    ST_POUT
  } state_e;

  localparam logic [16:0] ONE_Q15    = 17'd32768;
  localparam logic [15:0] HALF_Q15   = 16'd16384;
  localparam int          MIN_POINTS = 3;
  localparam logic [2:0]  MASK_RESET = 3'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_pts;
    logic app_pt;
    logic clr_rdy;
    logic ld_pix;
    logic bld_init;
    logic rd_pt;
    logic cap_pt;
    logic adv_k;
    logic sel_last;
    logic sel_first;
    logic mul_ab;
    logic mul_p1;
    logic mul_p2;
    logic div_init;
    logic div_step;
    logic sel_div;
    logic wr_ent;
    logic set_rdy;
    logic pix_rd;
    logic pix_out;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few_pts;
    logic cur_vld;
    logic hit;
    logic k_end;
    logic k_zero;
    logic div_done;
    logic i_last;
    logic out_busy;
  } sts_t;

endpackage

[design/tclm_ram.sv]
`timescale 1ns / 1ps
module tclm_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tclm_ctrl.sv]
`timescale 1ns / 1ps
module tclm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        command_i,
  output logic              in_ready_o,
  input  tclm_pkg::sts_t    sts_i,
  output tclm_pkg::ctl_t    ctl_o
);

  tclm_pkg::state_e state_q, state_d;
  logic             acc;

  assign acc        = in_valid_i && (state_q == tclm_pkg::ST_IDLE);
  assign in_ready_o = (state_q == tclm_pkg::ST_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tclm_pkg::ST_IDLE: begin
        if (acc && command_i == tclm_pkg::CMD_BUILD && !sts_i.few_pts) begin
          state_d = tclm_pkg::ST_BINIT;
        end else if (acc && command_i == tclm_pkg::CMD_MAP) begin
          state_d = tclm_pkg::ST_PRD;
        end
      end
      tclm_pkg::ST_BINIT: state_d = tclm_pkg::ST_CHK;
      tclm_pkg::ST_CHK: begin
        if (sts_i.k_end) begin
          state_d = tclm_pkg::ST_WR;
        end else if (!sts_i.cur_vld) begin
          state_d = tclm_pkg::ST_RD;
        end else if (sts_i.hit) begin
          state_d = sts_i.k_zero ? tclm_pkg::ST_WR : tclm_pkg::ST_AB;
        end
      end
      tclm_pkg::ST_RD:    state_d = tclm_pkg::ST_CAP;
      tclm_pkg::ST_CAP:   state_d = tclm_pkg::ST_CHK;
      tclm_pkg::ST_AB:    state_d = tclm_pkg::ST_P1;
      tclm_pkg::ST_P1:    state_d = tclm_pkg::ST_P2;
      tclm_pkg::ST_P2:    state_d = tclm_pkg::ST_DINIT;
      tclm_pkg::ST_DINIT: state_d = tclm_pkg::ST_DIV;
      tclm_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = tclm_pkg::ST_WR;
        end
      end
      tclm_pkg::ST_WR: begin
        state_d = sts_i.i_last ? tclm_pkg::ST_IDLE : tclm_pkg::ST_CHK;
      end
      tclm_pkg::ST_PRD:   state_d = tclm_pkg::ST_POUT;
      tclm_pkg::ST_POUT: begin
        if (!sts_i.out_busy) begin
          state_d = tclm_pkg::ST_IDLE;
        end
      end
      default: state_d = tclm_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl_o = '0;
    case (state_q)
      tclm_pkg::ST_IDLE: begin
        ctl_o.clr_pts = acc && command_i == tclm_pkg::CMD_CLEAR;
        ctl_o.app_pt  = acc && command_i == tclm_pkg::CMD_APPEND;
        ctl_o.clr_rdy = acc && (command_i == tclm_pkg::CMD_CLEAR ||
                                (command_i == tclm_pkg::CMD_BUILD && sts_i.few_pts));
        ctl_o.ld_pix  = acc && command_i == tclm_pkg::CMD_MAP;
      end
      tclm_pkg::ST_BINIT: ctl_o.bld_init = 1'b1;
      tclm_pkg::ST_CHK: begin
        if (sts_i.k_end) begin
          ctl_o.sel_last = 1'b1;
        end else if (sts_i.cur_vld && sts_i.hit && sts_i.k_zero) begin
          ctl_o.sel_first = 1'b1;
        end else if (sts_i.cur_vld && !sts_i.hit) begin
          ctl_o.adv_k = 1'b1;
        end
      end
      tclm_pkg::ST_RD:    ctl_o.rd_pt    = 1'b1;
      tclm_pkg::ST_CAP:   ctl_o.cap_pt   = 1'b1;
      tclm_pkg::ST_AB:    ctl_o.mul_ab   = 1'b1;
      tclm_pkg::ST_P1:    ctl_o.mul_p1   = 1'b1;
      tclm_pkg::ST_P2:    ctl_o.mul_p2   = 1'b1;
      tclm_pkg::ST_DINIT: ctl_o.div_init = 1'b1;
      tclm_pkg::ST_DIV: begin
        ctl_o.sel_div  = sts_i.div_done;
        ctl_o.div_step = !sts_i.div_done;
      end
      tclm_pkg::ST_WR: begin
        ctl_o.wr_ent  = 1'b1;
        ctl_o.set_rdy = sts_i.i_last;
      end
      tclm_pkg::ST_PRD:   ctl_o.pix_rd  = 1'b1;
      tclm_pkg::ST_POUT:  ctl_o.pix_out = !sts_i.out_busy;
      default: ctl_o = '0;
    endcase
  end

  // Hold state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tclm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/tclm_dp.sv]
`timescale 1ns / 1ps
module tclm_dp #(
  parameter int TableEntries = 256,
  parameter int MaxPoints    = 512
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_wdata_i,
  input  logic [15:0]    point_x_i,
  input  logic [15:0]    point_y_i,
  input  logic [15:0]    chan_a_i,
  input  logic [15:0]    chan_b_i,
  input  logic [15:0]    chan_c_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [15:0]    out_a_o,
  output logic [15:0]    out_b_o,
  output logic [15:0]    out_c_o,
  input  tclm_pkg::ctl_t ctl_i,
  output tclm_pkg::sts_t sts_o
);

  localparam int IW   = $clog2(TableEntries);
  localparam int PW   = $clog2(MaxPoints);
  localparam int CW   = PW + 1;
  localparam int XW   = 16 + IW;
  localparam int NW   = XW + 18;
  localparam int DCW  = $clog2(NW + 1);
  localparam int SPAN = TableEntries - 1;
  localparam int MW   = 17 + IW;

  logic [2:0]    mask_q;
  logic [CW-1:0] cnt_q;
  logic          rdy_q;
  logic [IW-1:0] i_q;
  logic [CW-1:0] k_q;
  logic          cur_vld_q;
  logic [XW-1:0] cur_x_q, prv_x_q, a_q, b_q, rem_q;
  logic [15:0]   cur_y_q, prv_y_q, quo_q, yres_q;
  logic [NW-1:0] p1_q, p2_q, num_q;
  logic [DCW-1:0] dcnt_q;
  logic [15:0]   chan_q [3];
  logic [15:0]   out_q [3];
  logic          out_vld_q;

  logic [15:0]   sat_x, sat_y;
  logic [31:0]   pt_rdata;
  logic [XW-1:0] ts, den, x_scaled;
  logic [XW:0]   rem_sh;
  logic [15:0]   entry;
  logic [15:0]   tbl_rdata [3];
  logic [IW-1:0] pix_idx [3];

  // Clamp appended points to 1.0.
  assign sat_x = ({1'b0, point_x_i} > tclm_pkg::ONE_Q15) ? 16'(tclm_pkg::ONE_Q15) : point_x_i;
  assign sat_y = ({1'b0, point_y_i} > tclm_pkg::ONE_Q15) ? 16'(tclm_pkg::ONE_Q15) : point_y_i;

  tclm_ram #(.Width(32), .Depth(MaxPoints)) u_pts (
    .clk_i   (clk_i),
    .we_i    (ctl_i.app_pt && (cnt_q < CW'(MaxPoints))),
    .waddr_i (cnt_q[PW-1:0]),
    .wdata_i ({sat_x, sat_y}),
    .re_i    (ctl_i.rd_pt),
    .raddr_i (k_q[PW-1:0]),
    .rdata_o (pt_rdata)
  );

  assign ts       = XW'({i_q, 15'b0});
  assign den      = a_q + b_q;
  assign x_scaled = XW'(XW'(pt_rdata[31:16]) * XW'(SPAN));
  assign rem_sh   = {rem_q, num_q[NW-1]};
  assign entry    = 16'(tclm_pkg::ONE_Q15 - {1'b0, yres_q});

  // Per-channel table index: round(v * span / 32768), clamped.
  for (genvar c = 0; c < 3; c++) begin : g_ch
    logic [MW-1:0] prod;
    logic [15:0]   v;
    assign v    = chan_q[c];
    assign prod = MW'(MW'(v) * MW'(SPAN)) + MW'(tclm_pkg::HALF_Q15);
    assign pix_idx[c] = (prod[MW-1:15] > (MW-15)'(SPAN)) ? IW'(SPAN) : prod[IW+14:15];

    tclm_ram #(.Width(16), .Depth(TableEntries)) u_tbl (
      .clk_i   (clk_i),
      .we_i    (ctl_i.wr_ent),
      .waddr_i (i_q),
      .wdata_i (entry),
      .re_i    (ctl_i.pix_rd),
      .raddr_i (pix_idx[c]),
      .rdata_o (tbl_rdata[c])
    );
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q    <= tclm_pkg::MASK_RESET;
      cnt_q     <= '0;
      rdy_q     <= 1'b0;
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      i_q       <= '0;
      k_q       <= '0;
      dcnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (ctl_i.clr_pts) begin
        cnt_q <= '0;
      end else if (ctl_i.app_pt && (cnt_q < CW'(MaxPoints))) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (ctl_i.clr_rdy) begin
        rdy_q <= 1'b0;
      end else if (ctl_i.set_rdy) begin
        rdy_q <= 1'b1;
      end
      if (ctl_i.bld_init) begin
        i_q       <= '0;
        k_q       <= '0;
        cur_vld_q <= 1'b0;
      end else begin
        if (ctl_i.cap_pt) begin
          cur_vld_q <= 1'b1;
        end
        if (ctl_i.adv_k) begin
          cur_vld_q <= 1'b0;
          k_q       <= k_q + CW'(1);
        end
        if (ctl_i.wr_ent) begin
          i_q <= i_q + IW'(1);
        end
      end
      if (ctl_i.div_init) begin
        dcnt_q <= DCW'(NW);
      end else if (ctl_i.div_step) begin
        dcnt_q <= dcnt_q - DCW'(1);
      end
      if (ctl_i.pix_out) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Scan, interpolation and divide payload.
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_pt) begin
      cur_x_q <= x_scaled;
      cur_y_q <= pt_rdata[15:0];
    end
    if (ctl_i.adv_k) begin
      prv_x_q <= cur_x_q;
      prv_y_q <= cur_y_q;
    end
    if (ctl_i.mul_ab) begin
      a_q <= ts - prv_x_q;
      b_q <= cur_x_q - ts;
    end
    if (ctl_i.mul_p1) begin
      p1_q <= NW'(prv_y_q) * NW'(b_q);
    end
    if (ctl_i.mul_p2) begin
      p2_q <= NW'(cur_y_q) * NW'(a_q);
    end
    if (ctl_i.div_init) begin
      num_q <= p1_q + p2_q + NW'(den >> 1);
      rem_q <= '0;
      quo_q <= '0;
    end else if (ctl_i.div_step) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den}) begin
        rem_q <= XW'(rem_sh - {1'b0, den});
        quo_q <= {quo_q[14:0], 1'b1};
      end else begin
        rem_q <= rem_sh[XW-1:0];
        quo_q <= {quo_q[14:0], 1'b0};
      end
    end
    if (ctl_i.sel_last) begin
      yres_q <= prv_y_q;
    end else if (ctl_i.sel_first) begin
      yres_q <= cur_y_q;
    end else if (ctl_i.sel_div) begin
      yres_q <= ({1'b0, quo_q} > tclm_pkg::ONE_Q15) ? 16'(tclm_pkg::ONE_Q15) : quo_q;
    end
  end

  // Pixel input and output registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_pix) begin
      chan_q[0] <= chan_a_i;
      chan_q[1] <= chan_b_i;
      chan_q[2] <= chan_c_i;
    end
    for (int c = 0; c < 3; c++) begin
      if (ctl_i.pix_out) begin
        out_q[c] <= (rdy_q && mask_q[c]) ? tbl_rdata[c] : chan_q[c];
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_a_o     = out_q[0];
  assign out_b_o     = out_q[1];
  assign out_c_o     = out_q[2];

  assign sts_o.few_pts  = cnt_q < CW'(tclm_pkg::MIN_POINTS);
  assign sts_o.cur_vld  = cur_vld_q;
  assign sts_o.hit      = cur_x_q >= ts;
  assign sts_o.k_end    = k_q == cnt_q;
  assign sts_o.k_zero   = k_q == '0;
  assign sts_o.div_done = dcnt_q == '0;
  assign sts_o.i_last   = i_q == IW'(SPAN);
  assign sts_o.out_busy = out_vld_q && !out_ready_i;

endmodule

[design/tone_curve_lut_mapper_top.sv]
`timescale 1ns / 1ps
// Channel | Handshake               | Payload
// in      | in_valid_i / in_ready_o | command, point_x, point_y, chan_a..c
// out     | out_valid_o/out_ready_i | out_a, out_b, out_c
// cfg     | cfg_we_i                | cfg_wdata_i (channel_mask)
// Clear, append and a build with fewer than three points finish on acceptance; map
// pixel runs accept, table read and output register states, plus output stalls.
// Build runs an init state, then per entry writes at once at the first or past the
// last point, or interpolates via multiply states and NW serial divider steps (NW =
// 34 + log2 TABLE_ENTRIES); the scan adds a read and capture per point it passes.
// Reset is asynchronous, active low; point and table memories are not cleared.
// A result left waiting in the output register holds the next pixel transaction
// in its output cycle, and the input stays blocked until the result drains.
module tone_curve_lut_mapper_top #(
  parameter int TABLE_ENTRIES = 256,
  parameter int MAX_POINTS    = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] point_x_i,
  input  logic [15:0] point_y_i,
  input  logic [15:0] chan_a_i,
  input  logic [15:0] chan_b_i,
  input  logic [15:0] chan_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_a_o,
  output logic [15:0] out_b_o,
  output logic [15:0] out_c_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i
);

  tclm_pkg::ctl_t ctl;
  tclm_pkg::sts_t sts;

  tclm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (command_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  tclm_dp #(.TableEntries(TABLE_ENTRIES), .MaxPoints(MAX_POINTS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .chan_a_i    (chan_a_i),
    .chan_b_i    (chan_b_i),
    .chan_c_i    (chan_c_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_a_o     (out_a_o),
    .out_b_o     (out_b_o),
    .out_c_o     (out_c_o),
    .ctl_i       (ctl),
    .sts_o       (sts)
  );

endmodule

[design/tclm_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tclm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  command_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] out_a_o
);

  // Hold a stalled result.
  `TCLM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `TCLM_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_a_o))

  // Drop nothing into the output for non-pixel transactions.
  `TCLM_ASSERT_NXT(a_no_spurious,
      in_valid_i && in_ready_o && command_i != tclm_pkg::CMD_MAP && !out_valid_o,
      !out_valid_o)

  // A pixel transaction keeps the input busy for the next cycle.
  `TCLM_ASSERT_NXT(a_map_busy,
      in_valid_i && in_ready_o && command_i == tclm_pkg::CMD_MAP, !in_ready_o)

endmodule

bind tone_curve_lut_mapper_top tclm_checker u_tclm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_a_o     (out_a_o)
);
